// ===== rtl/lea_pkg.sv =====
// Package for the LEA cipher core: constants, types and rotation helpers.
package lea_pkg;

  localparam int RkDepth  = 192;
  localparam int RkAddrW  = $clog2(RkDepth);
  localparam int RoundW   = 6;

  localparam logic [1:0] KEY_128 = 2'd0;
  localparam logic [1:0] KEY_192 = 2'd1;

  localparam logic [2:0] CFG_KEY_SIZE = 3'd0;
  localparam logic [2:0] CFG_KEY_01   = 3'd1;
  localparam logic [2:0] CFG_KEY_23   = 3'd2;
  localparam logic [2:0] CFG_KEY_45   = 3'd3;
  localparam logic [2:0] CFG_KEY_67   = 3'd4;

  localparam logic [0:0] OP_ENCRYPT = 1'b0;
  localparam logic [0:0] OP_DECRYPT = 1'b1;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [0:0] operation;
    word_t      block_word0;
    word_t      block_word1;
    word_t      block_word2;
    word_t      block_word3;
  } in_item_t;

  typedef struct packed {
    word_t result_word0;
    word_t result_word1;
    word_t result_word2;
    word_t result_word3;
  } out_item_t;

  function automatic word_t delta(input logic [2:0] idx);
    word_t d;
    case (idx)
      3'd0: d = 32'hc3efe9db;
      3'd1: d = 32'h44626b02;
      3'd2: d = 32'h79e27c8a;
      3'd3: d = 32'h78df30ec;
      3'd4: d = 32'h715ea49e;
      3'd5: d = 32'hc785da0a;
      3'd6: d = 32'he04ef22a;
      default: d = 32'he5c40957;
    endcase
    return d;
  endfunction

  function automatic word_t rotl(input word_t v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} << n;
    return t[63:32];
  endfunction

  function automatic word_t rotr(input word_t v, input logic [4:0] n);
    logic [63:0] t;
    t = {v, v} >> n;
    return t[31:0];
  endfunction

endpackage

// ===== rtl/lea_stream_if.sv =====
// Valid/ready channel interface carrying one payload.
interface lea_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/lea_ram.sv =====
// Generic single-port RAM with registered read.
module lea_ram #(
  parameter int Width = 32,
  parameter int Depth = 192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/lea_block_cipher_core.sv =====
// LEA block cipher core: key schedule sequencer, shared round unit and key RAM.
//
// One 128-bit block per input transfer, encrypt or decrypt. After a
// write of the key size or of a key word the next block first triggers a
// key expansion, one round key written per cycle into the single-port key
// RAM. Each block then, for each of its 24, 28 or 32 rounds with 128, 192
// or 256-bit keys, reads its six round keys one at a time from that RAM
// port and then applies the round. The result waits in an output register;
// the next block is taken only after the result has been transferred.
module lea_block_cipher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  lea_stream_if.sink   in_ch,
  lea_stream_if.source out_ch
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXPAND = 5'b00010,
    ST_FETCH  = 5'b00100,
    ST_ROUND  = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]  key_size_r;
  logic [63:0] key_r [4];
  logic        keys_ready_r;

  lea_pkg::word_t sw_r [8];
  lea_pkg::word_t blk_r [4];
  lea_pkg::word_t rk_r [6];
  logic [lea_pkg::RoundW-1:0] round_r;
  logic [2:0] sub_r;       // round key slot within a round
  logic [2:0] d6_r;        // round number modulo six, for the 192-bit schedule
  logic       op_r;

  logic [1:0] eff_size;
  logic [lea_pkg::RoundW-1:0] nrounds;
  assign eff_size = (key_size_r[1]) ? 2'd2 : key_size_r;
  assign nrounds  = (eff_size == lea_pkg::KEY_128) ? 6'd24 :
                    (eff_size == lea_pkg::KEY_192) ? 6'd28 : 6'd32;

  // Schedule word update for the current round and key slot.
  logic [2:0]  sw_idx;
  logic [2:0]  k_idx;
  logic [2:0]  d_idx;
  logic [4:0]  sh;
  lea_pkg::word_t sw_new;
  logic [8:0]  base9;
  logic [8:0]  sum9;
  always_comb begin
    base9 = 9'(round_r) * 9'd6;
    sum9  = base9 + 9'(sub_r);
    // A 128-bit key updates its fourth word in the slot that stores it.
    k_idx = (eff_size == lea_pkg::KEY_128 && sub_r == 3'd4) ? 3'd3 : sub_r;
    case (eff_size)
      lea_pkg::KEY_128: begin
        sw_idx = k_idx;
        d_idx  = {1'b0, round_r[1:0]};
      end
      lea_pkg::KEY_192: begin
        sw_idx = sub_r;
        d_idx  = d6_r;
      end
      default: begin
        sw_idx = sum9[2:0];
        d_idx  = round_r[2:0];
      end
    endcase
    case (k_idx)
      3'd0: sh = 5'd1;
      3'd1: sh = 5'd3;
      3'd2: sh = 5'd6;
      3'd3: sh = 5'd11;
      3'd4: sh = 5'd13;
      default: sh = 5'd17;
    endcase
    sw_new = lea_pkg::rotl(sw_r[sw_idx] + lea_pkg::rotl(lea_pkg::delta(d_idx),
             5'(round_r + 6'(k_idx))), sh);
  end

  // 128-bit key: six key stores per round, four of them word updates and two repeating the second word.
  lea_pkg::word_t exp_wdata;
  logic           exp_upd;
  always_comb begin
    exp_upd = 1'b1;
    exp_wdata = sw_new;
    if (eff_size == lea_pkg::KEY_128) begin
      case (sub_r)
        3'd3: begin exp_upd = 1'b0; exp_wdata = sw_r[1]; end
        3'd5: begin exp_upd = 1'b0; exp_wdata = sw_r[1]; end
        default: ;
      endcase
    end
  end

  // Round key address and RAM.
  logic [8:0] rk_addr9;
  logic       ram_we;
  lea_pkg::word_t ram_wdata, ram_rdata;
  logic [lea_pkg::RoundW-1:0] dec_round;
  assign dec_round = nrounds - 6'd1 - round_r;
  always_comb begin
    if (state_r == ST_EXPAND) begin
      rk_addr9 = sum9;
    end else if (op_r == lea_pkg::OP_DECRYPT) begin
      rk_addr9 = 9'(dec_round) * 9'd6 + 9'(sub_r);
    end else begin
      rk_addr9 = sum9;
    end
  end
  assign ram_we    = (state_r == ST_EXPAND);
  assign ram_wdata = exp_wdata;

  lea_ram #(.Width(32), .Depth(lea_pkg::RkDepth)) u_rk_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (rk_addr9[lea_pkg::RkAddrW-1:0]),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Round function on the gathered round keys.
  lea_pkg::word_t rnd [4];
  lea_pkg::word_t y1, y2, y3;
  always_comb begin
    y1 = (lea_pkg::rotr(blk_r[0], 5'd9) - (blk_r[3] ^ rk_r[0])) ^ rk_r[1];
    y2 = (lea_pkg::rotl(blk_r[1], 5'd5) - (y1 ^ rk_r[2])) ^ rk_r[3];
    y3 = (lea_pkg::rotl(blk_r[2], 5'd3) - (y2 ^ rk_r[4])) ^ rk_r[5];
    if (op_r == lea_pkg::OP_DECRYPT) begin
      rnd[0] = blk_r[3];
      rnd[1] = y1;
      rnd[2] = y2;
      rnd[3] = y3;
    end else begin
      rnd[0] = lea_pkg::rotl((blk_r[0] ^ rk_r[0]) + (blk_r[1] ^ rk_r[1]), 5'd9);
      rnd[1] = lea_pkg::rotr((blk_r[1] ^ rk_r[2]) + (blk_r[2] ^ rk_r[3]), 5'd5);
      rnd[2] = lea_pkg::rotr((blk_r[2] ^ rk_r[4]) + (blk_r[3] ^ rk_r[5]), 5'd3);
      rnd[3] = blk_r[0];
    end
  end

  logic last_round;
  assign last_round = (round_r == nrounds - 6'd1);
  logic in_xfer, out_xfer;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = (state_r == ST_OUT);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign out_ch.data.result_word0 = blk_r[0];
  assign out_ch.data.result_word1 = blk_r[1];
  assign out_ch.data.result_word2 = blk_r[2];
  assign out_ch.data.result_word3 = blk_r[3];

  // The fetch phase spends sub 0..5 issuing reads; read data arrives from the
  // registered RAM output in the next cycle, so sub 6 captures the last key and the round state runs.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_xfer) state_nxt = keys_ready_r ? ST_FETCH : ST_EXPAND;
      ST_EXPAND: if (last_round && sub_r == 3'd5) state_nxt = ST_FETCH;
      ST_FETCH:  if (sub_r == 3'd6) state_nxt = ST_ROUND;
      ST_ROUND:  state_nxt = last_round ? ST_OUT : ST_FETCH;
      ST_OUT:    if (out_xfer) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      key_size_r   <= 2'd0;
      keys_ready_r <= 1'b0;
      round_r      <= '0;
      sub_r        <= '0;
      d6_r         <= '0;
      for (int i = 0; i < 4; i++) begin
        key_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          lea_pkg::CFG_KEY_SIZE: begin
            key_size_r <= cfg_data[1:0];
            keys_ready_r <= 1'b0;
          end
          lea_pkg::CFG_KEY_01, lea_pkg::CFG_KEY_23, lea_pkg::CFG_KEY_45,
          lea_pkg::CFG_KEY_67: begin
            key_r[2'(cfg_index - lea_pkg::CFG_KEY_01)] <= cfg_data;
            keys_ready_r <= 1'b0;
          end
          default: ;
        endcase
      end
      unique case (state_r)
        ST_IDLE: begin
          round_r <= '0;
          sub_r   <= '0;
          d6_r    <= '0;
        end
        ST_EXPAND: begin
          if (sub_r == 3'd5) begin
            sub_r <= '0;
            round_r <= last_round ? '0 : round_r + 6'd1;
            d6_r <= (last_round || d6_r == 3'd5) ? 3'd0 : d6_r + 3'd1;
            if (last_round) keys_ready_r <= 1'b1;
          end else begin
            sub_r <= sub_r + 3'd1;
          end
        end
        ST_FETCH: begin
          sub_r <= (sub_r == 3'd6) ? 3'd0 : sub_r + 3'd1;
        end
        ST_ROUND: begin
          round_r <= last_round ? '0 : round_r + 6'd1;
        end
        ST_OUT: ;
        default: ;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_ch.data.operation;
      blk_r[0] <= in_ch.data.block_word0;
      blk_r[1] <= in_ch.data.block_word1;
      blk_r[2] <= in_ch.data.block_word2;
      blk_r[3] <= in_ch.data.block_word3;
      for (int i = 0; i < 4; i++) begin
        sw_r[2*i]   <= key_r[i][31:0];
        sw_r[2*i+1] <= key_r[i][63:32];
      end
    end
    if (state_r == ST_EXPAND && exp_upd) begin
      sw_r[sw_idx] <= sw_new;
    end
    if (state_r == ST_FETCH && sub_r != 3'd0) begin
      rk_r[3'(sub_r - 3'd1)] <= ram_rdata;
    end
    if (state_r == ST_ROUND) begin
      for (int i = 0; i < 4; i++) begin
        blk_r[i] <= rnd[i];
      end
    end
  end

`ifndef ASSERT_OFF
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_no_expand_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_xfer && keys_ready_r) |=> state_r == ST_FETCH)
    else $error("expansion started with valid keys");
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(blk_r[0]) && out_ch.valid)
    else $error("result changed while stalled");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    round_r < 6'd32)
    else $error("round counter out of range");
`endif

endmodule
